// ===== rtl/dqs_pkg.sv =====
// Shared types and codes for the double-ended queue with search.
// No dependencies; dqs_ctrl and the top level in rtl/ use this package.
package dqs_pkg;

    // Operation codes carried by an input beat.
    localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
    localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [2:0] OP_POP_BACK   = 3'd2;
    localparam logic [2:0] OP_POP_FRONT  = 3'd3;
    localparam logic [2:0] OP_FIND       = 3'd4;
    localparam logic [2:0] OP_REMOVE     = 3'd5;

    // Status codes carried by a result beat.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic        [2:0]  op;
        logic signed [31:0] value;
    } t_cmd;

    typedef struct packed {
        logic        [1:0]  status;
        logic signed [31:0] popped_value;
        logic        [5:0]  position;
        logic        [6:0]  entry_count;
    } t_result;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_SCAN,
        S_SHIFT
    } t_state;

endpackage

// ===== rtl/dqs_ram.sv =====
// Entry storage: one write port and one read port with registered read data.
// Depends on nothing outside this file.
module dqs_ram #(
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [31:0]              i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [31:0]              o_rd_data
);

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/dqs_ctrl.sv =====
// Sequencer for the queue: ring pointers, search scan and gap-closing shift.
// Depends on dqs_pkg; drives the ports of dqs_ram.
module dqs_ctrl #(
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    input  dqs_pkg::t_cmd            i_cmd,
    output logic                     busy,
    output logic                     o_done,
    output dqs_pkg::t_result         o_result,
    output logic                     o_wr_en,
    output logic [$clog2(DEPTH)-1:0] o_wr_addr,
    output logic [31:0]              o_wr_data,
    output logic [$clog2(DEPTH)-1:0] o_rd_addr,
    input  logic [31:0]              i_rd_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int OW = $clog2(DEPTH + 2);
    localparam logic [OW:0]   DEP1     = (OW + 1)'(DEPTH);
    localparam logic [OW:0]   DEP2     = (OW + 1)'(2 * DEPTH);
    localparam logic [CW-1:0] OCC_FULL = CW'(DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

    dqs_pkg::t_state r_state, n_state;
    logic [AW-1:0]   r_front, n_front;
    logic [CW-1:0]   r_occ,   n_occ;
    logic [CW-1:0]   r_idx,   n_idx;
    logic [CW-1:0]   r_pos,   n_pos;
    logic [2:0]      r_op,    n_op;
    logic [31:0]     r_value, n_value;
    logic            r_done,  n_done;
    dqs_pkg::t_result r_res,  n_res;

    logic [OW-1:0]   rd_off;
    logic            full;
    logic            empty;
    logic            scan_hit;
    logic            scan_last;
    logic            shift_more;
    logic [AW-1:0]   front_dec;
    logic [AW-1:0]   front_inc;

    // Ring slot of the entry at a given distance from the front.
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] front,
                                              input logic [OW-1:0] off);
        logic [OW:0] s;
        s = (OW + 1)'(front) + (OW + 1)'(off);
        if (s >= DEP2) begin
            s = s - DEP2;
        end else if (s >= DEP1) begin
            s = s - DEP1;
        end
        return s[AW-1:0];
    endfunction

    function automatic dqs_pkg::t_result mk_res(input logic [1:0]    status,
                                                input logic [31:0]   popped,
                                                input logic [CW-1:0] pos,
                                                input logic [CW-1:0] count);
        dqs_pkg::t_result res;
        logic [CW+5:0]    pos_ext;
        logic [CW+6:0]    cnt_ext;
        pos_ext          = {6'b0, pos};
        cnt_ext          = {7'b0, count};
        res.status       = status;
        res.popped_value = popped;
        res.position     = pos_ext[5:0];
        res.entry_count  = cnt_ext[6:0];
        return res;
    endfunction

    assign full       = (r_occ == OCC_FULL);
    assign empty      = (r_occ == '0);
    assign scan_hit   = (i_rd_data == r_value);
    assign scan_last  = ((r_idx + CW'(1)) == r_occ);
    assign shift_more = ((CW + 1)'(r_idx) + (CW + 1)'(1)) < (CW + 1)'(r_occ);
    assign front_dec  = (r_front == '0) ? LAST_SLOT : r_front - AW'(1);
    assign front_inc  = (r_front == LAST_SLOT) ? '0 : r_front + AW'(1);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dqs_pkg::S_IDLE: begin
                if (start) begin
                    if ((i_cmd.op == dqs_pkg::OP_POP_BACK ||
                         i_cmd.op == dqs_pkg::OP_POP_FRONT) && !empty) begin
                        n_state = dqs_pkg::S_POP;
                    end else if ((i_cmd.op == dqs_pkg::OP_FIND ||
                                  i_cmd.op == dqs_pkg::OP_REMOVE) && !empty) begin
                        n_state = dqs_pkg::S_SCAN;
                    end
                end
            end
            dqs_pkg::S_POP: begin
                n_state = dqs_pkg::S_IDLE;
            end
            dqs_pkg::S_SCAN: begin
                if (scan_hit) begin
                    n_state = (r_op == dqs_pkg::OP_REMOVE) ? dqs_pkg::S_SHIFT
                                                           : dqs_pkg::S_IDLE;
                end else if (scan_last) begin
                    n_state = dqs_pkg::S_IDLE;
                end
            end
            dqs_pkg::S_SHIFT: begin
                if (!shift_more) begin
                    n_state = dqs_pkg::S_IDLE;
                end
            end
            default: n_state = dqs_pkg::S_IDLE;
        endcase
    end

    // Datapath and memory control. Reads run one entry ahead of the compare,
    // so during the shift the write to slot j overlaps the read of slot j+2.
    always_comb begin
        n_front   = r_front;
        n_occ     = r_occ;
        n_idx     = r_idx;
        n_pos     = r_pos;
        n_op      = r_op;
        n_value   = r_value;
        n_done    = 1'b0;
        n_res     = r_res;
        o_wr_en   = 1'b0;
        o_wr_addr = slot_of(r_front, OW'(r_occ));
        o_wr_data = r_value;
        rd_off    = '0;
        unique case (r_state)
            dqs_pkg::S_IDLE: begin
                if (start) begin
                    n_op      = i_cmd.op;
                    n_value   = i_cmd.value;
                    o_wr_data = i_cmd.value;
                    n_idx     = '0;
                    unique case (i_cmd.op)
                        dqs_pkg::OP_PUSH_BACK: begin
                            n_done = 1'b1;
                            if (full) begin
                                n_res = mk_res(dqs_pkg::ST_FULL, '0, '0, r_occ);
                            end else begin
                                o_wr_en = 1'b1;
                                n_occ   = r_occ + CW'(1);
                                n_res   = mk_res(dqs_pkg::ST_OK, '0, '0, r_occ + CW'(1));
                            end
                        end
                        dqs_pkg::OP_PUSH_FRONT: begin
                            n_done    = 1'b1;
                            o_wr_addr = front_dec;
                            if (full) begin
                                n_res = mk_res(dqs_pkg::ST_FULL, '0, '0, r_occ);
                            end else begin
                                o_wr_en = 1'b1;
                                n_front = front_dec;
                                n_occ   = r_occ + CW'(1);
                                n_res   = mk_res(dqs_pkg::ST_OK, '0, '0, r_occ + CW'(1));
                            end
                        end
                        dqs_pkg::OP_POP_BACK, dqs_pkg::OP_POP_FRONT: begin
                            if (i_cmd.op == dqs_pkg::OP_POP_BACK) begin
                                rd_off = OW'(r_occ - CW'(1));
                            end
                            if (empty) begin
                                n_done = 1'b1;
                                n_res  = mk_res(dqs_pkg::ST_EMPTY, '0, '0, r_occ);
                            end
                        end
                        dqs_pkg::OP_FIND, dqs_pkg::OP_REMOVE: begin
                            if (empty) begin
                                n_done = 1'b1;
                                n_res  = mk_res(dqs_pkg::ST_NOT_FOUND, '0, '0, r_occ);
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                            n_res  = mk_res(dqs_pkg::ST_OK, '0, '0, r_occ);
                        end
                    endcase
                end
            end
            dqs_pkg::S_POP: begin
                n_done = 1'b1;
                n_occ  = r_occ - CW'(1);
                if (r_op == dqs_pkg::OP_POP_FRONT) begin
                    n_front = front_inc;
                end
                n_res = mk_res(dqs_pkg::ST_OK, i_rd_data, '0, r_occ - CW'(1));
            end
            dqs_pkg::S_SCAN: begin
                rd_off = OW'(r_idx) + OW'(1);
                if (scan_hit) begin
                    n_pos = r_idx;
                    if (r_op == dqs_pkg::OP_FIND) begin
                        n_done = 1'b1;
                        n_res  = mk_res(dqs_pkg::ST_OK, '0, r_idx, r_occ);
                    end
                end else if (scan_last) begin
                    n_done = 1'b1;
                    n_res  = mk_res(dqs_pkg::ST_NOT_FOUND, '0, '0, r_occ);
                end else begin
                    n_idx = r_idx + CW'(1);
                end
            end
            dqs_pkg::S_SHIFT: begin
                rd_off = OW'(r_idx) + OW'(2);
                if (shift_more) begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = slot_of(r_front, OW'(r_idx));
                    o_wr_data = i_rd_data;
                    n_idx     = r_idx + CW'(1);
                end else begin
                    n_done = 1'b1;
                    n_occ  = r_occ - CW'(1);
                    n_res  = mk_res(dqs_pkg::ST_OK, '0, r_pos, r_occ - CW'(1));
                end
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    assign o_rd_addr = slot_of(r_front, rd_off);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dqs_pkg::S_IDLE;
            r_front <= '0;
            r_occ   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_occ   <= n_occ;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_pos   <= n_pos;
        r_op    <= n_op;
        r_value <= n_value;
        r_res   <= n_res;
    end

    assign busy     = (r_state != dqs_pkg::S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_res;

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CW + 1)'(r_occ) <= (CW + 1)'(DEPTH))
        else $error("occupancy above depth");

    a_front_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (AW + 1)'(r_front) < (AW + 1)'(DEPTH))
        else $error("front index outside the ring");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_state == dqs_pkg::S_IDLE)
        else $error("result beat while still working");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd.op == dqs_pkg::OP_PUSH_BACK && !full)
        |=> (r_done && r_occ == $past(r_occ) + CW'(1)))
        else $error("push did not add one entry");

    a_shift_no_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dqs_pkg::S_SHIFT && o_wr_en && (CW + 1)'(r_idx) + (CW + 1)'(2)
            < (CW + 1)'(r_occ)) |-> o_wr_addr != o_rd_addr)
        else $error("shift write collides with the look-ahead read");

endmodule

// ===== rtl/double_ended_queue_with_search.sv =====
// Top level of the bounded double-ended queue with find and remove.
// Depends on dqs_pkg, dqs_ram and dqs_ctrl.
//
// A command beat is taken when start is high and busy is low; its result
// appears on o_result for exactly one cycle with o_done high, and the
// receiver cannot hold it off. Pushes and refused or empty operations give
// their result in the cycle after the command; pops pass through the pop
// state first. Find and remove walk the single read port of the entry
// memory one entry per cycle, the remove then moving the later entries
// forward through the same port. No clearing pass follows reset; the
// queue is usable at once.
module double_ended_queue_with_search #(
    parameter int DEPTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  dqs_pkg::t_cmd     i_cmd,
    output logic              busy,
    output logic              o_done,
    output dqs_pkg::t_result  o_result
);

    localparam int AW = $clog2(DEPTH);

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;
    logic [AW-1:0] rd_addr;
    logic [31:0]   rd_data;

    dqs_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_cmd     (i_cmd),
        .busy      (busy),
        .o_done    (o_done),
        .o_result  (o_result),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data)
    );

    dqs_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

endmodule
